### rtl/rcfd_pkg.sv
// Shared types and constants for the radio-control channel frame decoder.
// No dependencies; every other file of the block refers to this package.
package rcfd_pkg;

	// Frame layout
	localparam int FRAME_BYTES   = 32;
	localparam int CHANNEL_SLOTS = 14;
	localparam int POS_W         = 5;
	localparam logic [POS_W-1:0] POS_LEN       = 5'd0;
	localparam logic [POS_W-1:0] POS_CMD       = 5'd1;
	localparam logic [POS_W-1:0] POS_SUM_LAST  = 5'd29;
	localparam logic [POS_W-1:0] POS_CHECK_LO  = 5'd30;
	localparam logic [POS_W-1:0] POS_CHECK_HI  = 5'd31;
	localparam logic [POS_W-1:0] POS_FIRST_HI  = 5'd3;

	localparam logic [15:0] SUM_SEED = 16'hFFFF;
	localparam int MS_W = 17;
	localparam logic [MS_W-1:0] MS_MAX = 17'h1FFFF;

	// Configuration register reset values
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [7:0]  LENGTH_RESET  = 8'd32;
	localparam logic [7:0]  COMMAND_RESET = 8'd64;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT = 2'd0,
		REG_LENGTH  = 2'd1,
		REG_COMMAND = 2'd2,
		REG_UNUSED  = 2'd3
	} reg_idx_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CHANNEL  = 2'd0,
		KIND_BAD_HDR  = 2'd1,
		KIND_CHECKSUM = 2'd2,
		KIND_STATUS   = 2'd3
	} kind_t;

	// Job handed from front to back; KIND_CHANNEL means a channel run
	typedef struct packed {
		kind_t kind;
		logic  lost;
	} job_t;

	// Channel store write request from front to back
	typedef struct packed {
		logic        en;
		logic [3:0]  ch;
		logic [15:0] value;
	} store_wr_t;

	// Configuration seen by the front
	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [7:0]  expected_length;
		logic [7:0]  expected_command;
	} cfg_t;

	localparam int QDEPTH = 2;

endpackage

### rtl/rc_channel_frame_decoder.sv
// Radio-control channel frame decoder. Each request carries one received byte
// (mode 0) or one millisecond tick (mode 1); bytes are frame-aligned from reset
// in 32-byte frames. The last byte of a frame gives either one error result
// or, for a good frame, USER_CHANNELS channel results that leave the output
// register at one per cycle while out_stall is low; while such a run drains,
// further bytes are stalled (ticks are still taken, up to the two-entry job
// queue). Each tick gives one status result with the signal-lost flag.
// Configuration writes are always ready; index 3 is ignored.
module rc_channel_frame_decoder #(
	parameter int USER_CHANNELS = rcfd_pkg::CHANNEL_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [3:0]                    channel_index,
	output logic [15:0]                   channel_value,
	output logic                          signal_lost,
	output logic                          last
);

	rcfd_pkg::cfg_t       cfg_q;
	rcfd_pkg::store_wr_t  store_wr;
	rcfd_pkg::job_t       push_job;
	rcfd_pkg::job_t       head_job;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_not_empty;
	logic                 run_done;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms       <= rcfd_pkg::TIMEOUT_RESET;
			cfg_q.expected_length  <= rcfd_pkg::LENGTH_RESET;
			cfg_q.expected_command <= rcfd_pkg::COMMAND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rcfd_pkg::reg_idx_t'(cfg_index))
				rcfd_pkg::REG_TIMEOUT: cfg_q.timeout_ms       <= cfg_data;
				rcfd_pkg::REG_LENGTH:  cfg_q.expected_length  <= cfg_data[7:0];
				rcfd_pkg::REG_COMMAND: cfg_q.expected_command <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	rcfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.rx_byte  (rx_byte),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job),
		.store_wr (store_wr),
		.run_done (run_done)
	);

	rcfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	rcfd_back #(
		.USER_CHANNELS (USER_CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.store_wr      (store_wr),
		.q_not_empty   (q_not_empty),
		.q_head        (head_job),
		.q_pop         (q_pop),
		.run_done      (run_done),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.signal_lost   (signal_lost),
		.last          (last)
	);

endmodule

### rtl/rcfd_front.sv
// Front end: accepts bytes and ticks, tracks frame position, header, checksum
// and the signal-loss timer, and pushes jobs. Depends on rcfd_pkg.
module rcfd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [7:0]           rx_byte,
	input  rcfd_pkg::cfg_t       cfg,
	input  logic                 q_full,
	output logic                 q_push,
	output rcfd_pkg::job_t       q_job,
	output rcfd_pkg::store_wr_t  store_wr,
	input  logic                 run_done
);

	logic [rcfd_pkg::POS_W-1:0] pos_q;
	logic [15:0]                sum_q;
	logic                       hdr_ok_q;
	logic [7:0]                 pend_q;
	logic                       seen_q;
	logic [rcfd_pkg::MS_W-1:0]  ms_q;
	logic                       run_busy_q;

	logic                       accept;
	logic                       is_byte;
	logic                       is_tick;
	logic [15:0]                rx_sum;
	logic [rcfd_pkg::MS_W-1:0]  ms_inc;
	logic                       frame_good;
	logic [rcfd_pkg::POS_W-1:0] ch_off;

	// Hold everything when the queue is full; hold bytes while a run drains,
	// since later bytes would overwrite the channel store
	assign in_stall = q_full || (run_busy_q && !mode);
	assign accept   = in_valid && !in_stall;
	assign is_byte  = accept && !mode;
	assign is_tick  = accept && mode;

	assign rx_sum     = {rx_byte, pend_q};
	assign frame_good = hdr_ok_q && (rx_sum == sum_q);
	assign ms_inc     = (ms_q < rcfd_pkg::MS_MAX) ? ms_q + 1'b1 : ms_q;
	assign ch_off     = (pos_q - rcfd_pkg::POS_FIRST_HI) >> 1;

	// Store write on the high byte of each channel pair
	always_comb begin
		store_wr.en    = is_byte && pos_q[0] && (pos_q >= rcfd_pkg::POS_FIRST_HI)
			&& (pos_q <= rcfd_pkg::POS_SUM_LAST);
		store_wr.ch    = ch_off[3:0];
		store_wr.value = {rx_byte, pend_q};
	end

	// Job push: end of frame or tick
	always_comb begin
		q_push     = is_tick || (is_byte && (pos_q == rcfd_pkg::POS_CHECK_HI));
		q_job.kind = rcfd_pkg::KIND_STATUS;
		q_job.lost = 1'b0;
		if (is_tick) begin
			q_job.kind = rcfd_pkg::KIND_STATUS;
			q_job.lost = seen_q && (ms_inc > {1'b0, cfg.timeout_ms});
		end else if (!hdr_ok_q) begin
			q_job.kind = rcfd_pkg::KIND_BAD_HDR;
		end else if (rx_sum != sum_q) begin
			q_job.kind = rcfd_pkg::KIND_CHECKSUM;
		end else begin
			q_job.kind = rcfd_pkg::KIND_CHANNEL;
		end
	end

	// Frame and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			sum_q      <= rcfd_pkg::SUM_SEED;
			hdr_ok_q   <= 1'b0;
			pend_q     <= '0;
			seen_q     <= 1'b0;
			ms_q       <= '0;
			run_busy_q <= 1'b0;
		end else begin
			if (run_done) begin
				run_busy_q <= 1'b0;
			end
			if (is_tick) begin
				ms_q <= ms_inc;
			end
			if (is_byte) begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == rcfd_pkg::POS_LEN) begin
					hdr_ok_q <= (rx_byte == cfg.expected_length);
					sum_q    <= rcfd_pkg::SUM_SEED - {8'd0, rx_byte};
				end else if (pos_q == rcfd_pkg::POS_CMD) begin
					hdr_ok_q <= hdr_ok_q && (rx_byte == cfg.expected_command);
					sum_q    <= sum_q - {8'd0, rx_byte};
				end else if (pos_q <= rcfd_pkg::POS_SUM_LAST) begin
					sum_q <= sum_q - {8'd0, rx_byte};
					if (!pos_q[0]) begin
						pend_q <= rx_byte;
					end
				end else if (pos_q == rcfd_pkg::POS_CHECK_LO) begin
					pend_q <= rx_byte;
				end else if (frame_good) begin
					// Good frame: start a channel run, restart the timer
					seen_q     <= 1'b1;
					ms_q       <= '0;
					run_busy_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/rcfd_queue.sv
// Two-entry job queue between front and back.
// Depends on rcfd_pkg for the job type and depth.
module rcfd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rcfd_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output rcfd_pkg::job_t  head
);

	localparam int PtrW = $clog2(rcfd_pkg::QDEPTH);

	rcfd_pkg::job_t      mem_q [rcfd_pkg::QDEPTH];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [PtrW:0]       count_q;

	assign full      = (count_q == (PtrW+1)'(rcfd_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/rcfd_back.sv
// Back end: holds the channel store, pops jobs and drives the result register,
// walking through the channels for a good frame. Depends on rcfd_pkg.
module rcfd_back #(
	parameter int USER_CHANNELS = rcfd_pkg::CHANNEL_SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rcfd_pkg::store_wr_t  store_wr,
	input  logic                 q_not_empty,
	input  rcfd_pkg::job_t       q_head,
	output logic                 q_pop,
	output logic                 run_done,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [3:0]           channel_index,
	output logic [15:0]          channel_value,
	output logic                 signal_lost,
	output logic                 last
);

	localparam int IdxW = (USER_CHANNELS > 1) ? $clog2(USER_CHANNELS) : 1;
	localparam logic [3:0] LastCh = 4'(USER_CHANNELS - 1);

	logic [15:0]          store_q [USER_CHANNELS];
	logic                 run_q;
	logic [3:0]           next_ch_q;
	logic                 out_valid_q;
	rcfd_pkg::kind_t      kind_q;
	logic [3:0]           idx_q;
	logic [15:0]          value_q;
	logic                 lost_q;
	logic                 last_q;

	logic                 fire;
	logic                 load;
	logic [3:0]           emit_ch;

	assign fire     = out_valid_q && !out_stall;
	assign load     = !out_valid_q || fire;
	assign q_pop    = load && !run_q && q_not_empty;
	assign run_done = fire && (kind_q == rcfd_pkg::KIND_CHANNEL) && last_q;
	assign emit_ch  = run_q ? next_ch_q : 4'd0;

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign channel_index = idx_q;
	assign channel_value = value_q;
	assign signal_lost   = lost_q;
	assign last          = last_q;

	// Channel store
	always_ff @(posedge clk) begin
		if (store_wr.en && (store_wr.ch < 4'(USER_CHANNELS))) begin
			store_q[store_wr.ch[IdxW-1:0]] <= store_wr.value;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load && (run_q || q_not_empty)) begin
			if (run_q || (q_head.kind == rcfd_pkg::KIND_CHANNEL)) begin
				kind_q  <= rcfd_pkg::KIND_CHANNEL;
				idx_q   <= emit_ch;
				value_q <= store_q[emit_ch[IdxW-1:0]];
				lost_q  <= 1'b0;
				last_q  <= (emit_ch == LastCh);
			end else begin
				kind_q  <= q_head.kind;
				idx_q   <= '0;
				value_q <= '0;
				lost_q  <= q_head.lost;
				last_q  <= 1'b1;
			end
		end
	end

	// Output valid and channel run counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_q       <= 1'b0;
			next_ch_q   <= '0;
		end else if (load) begin
			out_valid_q <= run_q || q_not_empty;
			if (run_q || (q_not_empty && (q_head.kind == rcfd_pkg::KIND_CHANNEL))) begin
				run_q     <= (emit_ch != LastCh);
				next_ch_q <= emit_ch + 1'b1;
			end
		end
	end

endmodule
